[rtl/core/lswt_pkg.sv]
package lswt_pkg;

    localparam int SEQ_W    = 3;
    localparam int VERDICT_W = 2;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;

    localparam logic [SEQ_W-1:0] LIMIT_RESET  = 3'd7;
    localparam logic [SEQ_W-1:0] ACKED_RESET  = 3'd7;
    localparam logic [SEQ_W-1:0] CREDIT_RESET = 3'd1;
    localparam logic [SEQ_W-1:0] OUT_MAX      = 3'd7;

    typedef enum logic [2:0] {
        OP_RESET    = 3'd0,
        OP_SENT     = 3'd1,
        OP_ACCEPTED = 3'd2,
        OP_CHECK_NS = 3'd3,
        OP_CHECK_NR = 3'd4,
        OP_ACK_NR   = 3'd5
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_NONE       = 2'd0,
        V_EXPECTED   = 2'd1,
        V_UNEXPECTED = 2'd2,
        V_INVALID    = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [SEQ_W-1:0] pending;
        logic [SEQ_W-1:0] acked_seq;
        logic [SEQ_W-1:0] recv_seq;
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] credit;
        logic [SEQ_W-1:0] removed;
        verdict_t         verdict;
    } result_t;

endpackage

[rtl/core/lap_sliding_window_tracker_unit.sv]
// Modulo-8 sliding-window tracker for one link. Each request (op, seq) is
// worked combinationally against the held sequence state and yields one
// result carrying the verdict, the frames released and the state after the
// request. A new request is taken in every cycle; the result goes into a
// two-entry output buffer, so one more request is taken while a result
// waits, and s_tready falls only when both entries are full. The window
// limit is written over the cfg channel, which is always ready, and
// resets to 7.
module lap_sliding_window_tracker_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lswt_pkg::SEQ_W-1:0] cfg_data,   // window_limit
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [lswt_pkg::IN_W-1:0] s_tdata,     // op[2:0], seq[5:3]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [lswt_pkg::OUT_W-1:0] m_tdata     // verdict[1:0], removed[4:2],
                                                  // credit[7:5], send_seq[10:8],
                                                  // recv_seq[13:11], acked_seq[16:14],
                                                  // pending[19:17]
);
    import lswt_pkg::*;

    logic [SEQ_W-1:0] limit_reg;
    logic [SEQ_W-1:0] send_reg, send_next;
    logic [SEQ_W-1:0] recv_reg, recv_next;
    logic [SEQ_W-1:0] acked_reg, acked_next;
    logic [SEQ_W-1:0] pend_reg, pend_next;
    logic [SEQ_W-1:0] credit_reg, credit_next;

    logic             head_valid_reg, skid_valid_reg;
    result_t          head_reg, skid_reg;
    result_t          res;

    logic [2:0]       op_raw;
    logic [SEQ_W-1:0] seq;
    logic             push, pop, head_load;
    logic [SEQ_W-1:0] gap, rel;
    verdict_t         verdict;
    logic [SEQ_W-1:0] removed;

    assign op_raw = s_tdata[2:0];
    assign seq    = s_tdata[5:3];

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign push      = s_tvalid && s_tready;
    assign pop       = head_valid_reg && m_tready;
    assign head_load = pop || !head_valid_reg;

    assign gap = seq - acked_reg - 3'd1;
    assign rel = (pend_reg < gap) ? pend_reg : gap;

    always_comb
    begin
        send_next   = send_reg;
        recv_next   = recv_reg;
        acked_next  = acked_reg;
        pend_next   = pend_reg;
        credit_next = credit_reg;
        verdict     = V_NONE;
        removed     = '0;
        case (op_raw)
            OP_RESET:
            begin
                send_next   = '0;
                recv_next   = '0;
                acked_next  = ACKED_RESET;
                pend_next   = '0;
                credit_next = CREDIT_RESET;
            end
            OP_SENT:
            begin
                send_next = send_reg + 3'd1;
                if (pend_reg < OUT_MAX)
                    pend_next = pend_reg + 3'd1;
                if (credit_reg != '0)
                    credit_next = credit_reg - 3'd1;
            end
            OP_ACCEPTED:
                recv_next = recv_reg + 3'd1;
            OP_CHECK_NS:
                verdict = (seq == recv_reg) ? V_EXPECTED : V_UNEXPECTED;
            OP_CHECK_NR:
            begin
                if (seq == send_reg)
                    verdict = V_EXPECTED;
                else if (acked_reg < send_reg)
                    verdict = (seq >= acked_reg && seq <= send_reg) ? V_UNEXPECTED
                                                                    : V_INVALID;
                else
                    verdict = (seq >= acked_reg || seq <= send_reg) ? V_UNEXPECTED
                                                                    : V_INVALID;
            end
            OP_ACK_NR:
            begin
                if (seq == send_reg)
                begin
                    removed    = pend_reg;
                    pend_next  = '0;
                    acked_next = seq - 3'd1;
                end
                else
                begin
                    removed    = rel;
                    pend_next  = pend_reg - rel;
                    acked_next = acked_reg + rel;
                end
                credit_next = (limit_reg > pend_next) ? (limit_reg - pend_next) : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.verdict   = verdict;
        res.removed   = removed;
        res.credit    = credit_next;
        res.send_seq  = send_next;
        res.recv_seq  = recv_next;
        res.acked_seq = acked_next;
        res.pending   = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LIMIT_RESET;
            send_reg       <= '0;
            recv_reg       <= '0;
            acked_reg      <= ACKED_RESET;
            pend_reg       <= '0;
            credit_reg     <= CREDIT_RESET;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (push)
            begin
                send_reg   <= send_next;
                recv_reg   <= recv_next;
                acked_reg  <= acked_next;
                pend_reg   <= pend_next;
                credit_reg <= credit_next;
            end
            if (head_load)
            begin
                head_valid_reg <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else if (push)
                skid_valid_reg <= 1'b1;
        end
    end

    // hold payload; refill head from skid first
    always_ff @(posedge clk)
    begin
        if (head_load)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
                if (push)
                    skid_reg <= res;
            end
            else if (push)
                head_reg <= res;
        end
        else if (push)
            skid_reg <= res;
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {4'd0, head_reg};

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held without head entry");

    a_window_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pend_reg} + {1'b0, credit_reg}) <= 4'd7)
        else $error("outstanding plus credit exceeds window");

    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        (push && op_raw == OP_RESET) |=>
            (pend_reg == '0 && credit_reg == CREDIT_RESET && acked_reg == ACKED_RESET))
        else $error("connection reset left stale state");

    a_ack_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && op_raw == OP_ACK_NR) |=> pend_reg <= $past(pend_reg))
        else $error("acknowledge grew outstanding count");

    a_verdict_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head_reg.verdict != V_NONE) |-> head_reg.removed == '0)
        else $error("verdict and release reported together");

endmodule
